[rtl/pptab_pkg.sv]
// Shared constants and codes for the promotable priority table.
package pptab_pkg;

  localparam int CAPACITY       = 64;
  localparam int PAYLOAD_WIDTH  = 32;
  localparam int ID_WIDTH       = 16;
  localparam int PRIORITY_WIDTH = 16;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD     = 3'd0,
    FN_PROMOTE = 3'd1,
    FN_PEEK    = 3'd2,
    FN_POP     = 3'd3,
    FN_LOOKUP  = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_EXHAUSTED = 3'd4,
    ST_SATURATED = 3'd5
  } status_t;

endpackage

[rtl/pptab_if.sv]
// Command and response channel interfaces of the promotable priority table.
interface pptab_in_if #(
  parameter int ID_WIDTH      = pptab_pkg::ID_WIDTH,
  parameter int PAYLOAD_WIDTH = pptab_pkg::PAYLOAD_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic [pptab_pkg::FUNC_W-1:0] func;
  logic [ID_WIDTH-1:0]         item_id;
  logic [PAYLOAD_WIDTH-1:0]    payload_in;

  modport source(output valid, func, item_id, payload_in, input ready);
  modport sink(input valid, func, item_id, payload_in, output ready);
endinterface

interface pptab_out_if #(
  parameter int ID_WIDTH       = pptab_pkg::ID_WIDTH,
  parameter int PAYLOAD_WIDTH  = pptab_pkg::PAYLOAD_WIDTH,
  parameter int PRIORITY_WIDTH = pptab_pkg::PRIORITY_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic [pptab_pkg::STATUS_W-1:0] status;
  logic [ID_WIDTH-1:0]           result_id;
  logic [PAYLOAD_WIDTH-1:0]      payload_out;
  logic [PRIORITY_WIDTH-1:0]     priority_out;
  logic                          present;

  modport source(output valid, status, result_id, payload_out, priority_out, present,
                 input ready);
  modport sink(input valid, status, result_id, payload_out, priority_out, present,
               output ready);
endinterface

[rtl/pptab_cell.sv]
// One table slot: holds an entry and folds it into the sweep record passing by.
module pptab_cell #(
  parameter int  INDEX          = 0,
  parameter int  IDX_W          = 6,
  parameter int  ID_WIDTH       = pptab_pkg::ID_WIDTH,
  parameter int  PAYLOAD_WIDTH  = pptab_pkg::PAYLOAD_WIDTH,
  parameter int  PRIORITY_WIDTH = pptab_pkg::PRIORITY_WIDTH,
  parameter type sweep_t        = logic,
  parameter type act_t          = logic
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ID_WIDTH-1:0] cmd_id,
  input  sweep_t              upstream,
  output sweep_t              downstream,
  input  act_t                act
);

  logic                      valid;
  logic [ID_WIDTH-1:0]       ident;
  logic [PRIORITY_WIDTH-1:0] prio;
  logic [PAYLOAD_WIDTH-1:0]  payload;
  sweep_t                    downstream_next;
  logic                      mine;

  assign mine = (act.idx == IDX_W'(INDEX));

  always_comb begin
    downstream_next = upstream;
    if (!upstream.hit && valid && ident == cmd_id) begin
      downstream_next.hit      = 1'b1;
      downstream_next.hit_idx  = IDX_W'(INDEX);
      downstream_next.hit_prio = prio;
      downstream_next.hit_pay  = payload;
    end
    if (!upstream.free && !valid) begin
      downstream_next.free     = 1'b1;
      downstream_next.free_idx = IDX_W'(INDEX);
    end
    // ties on priority go to the newer (larger) id
    if (valid && (!upstream.best || prio > upstream.best_prio ||
                  (prio == upstream.best_prio && ident > upstream.best_id))) begin
      downstream_next.best      = 1'b1;
      downstream_next.best_idx  = IDX_W'(INDEX);
      downstream_next.best_prio = prio;
      downstream_next.best_id   = ident;
      downstream_next.best_pay  = payload;
    end
  end

  always_ff @(posedge clk) begin
    downstream <= downstream_next;
    if (rst) begin
      valid <= 1'b0;
    end else if (mine) begin
      if (act.wr) begin
        valid <= 1'b1;
      end else if (act.clr) begin
        valid <= 1'b0;
      end
    end
    if (mine && act.wr) begin
      ident   <= act.id;
      prio    <= '0;
      payload <= act.pay;
    end else if (mine && act.inc) begin
      prio <= prio + 1'b1;
    end
  end

endmodule

[rtl/promotable_priority_table.sv]
// Promotable priority table: top level with sequencer and chain of slot cells.
// A command word is captured, swept through the cell chain, one cell per cycle, then
// decided and written back in the FIN state, which waits while the previous response
// is still held. A new command is accepted only in IDLE, after the write-back.
// A new command is taken while the previous response still waits.
// Reset clears all slot valid bits, the id counter and the response valid.
module promotable_priority_table #(
  parameter int CAPACITY       = pptab_pkg::CAPACITY,
  parameter int PAYLOAD_WIDTH  = pptab_pkg::PAYLOAD_WIDTH,
  parameter int ID_WIDTH       = pptab_pkg::ID_WIDTH,
  parameter int PRIORITY_WIDTH = pptab_pkg::PRIORITY_WIDTH
) (
  input logic        clk,
  input logic        rst,
  pptab_in_if.sink   cmd,
  pptab_out_if.source rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic                      hit;
    logic [IDX_W-1:0]          hit_idx;
    logic [PRIORITY_WIDTH-1:0] hit_prio;
    logic [PAYLOAD_WIDTH-1:0]  hit_pay;
    logic                      free;
    logic [IDX_W-1:0]          free_idx;
    logic                      best;
    logic [IDX_W-1:0]          best_idx;
    logic [PRIORITY_WIDTH-1:0] best_prio;
    logic [ID_WIDTH-1:0]       best_id;
    logic [PAYLOAD_WIDTH-1:0]  best_pay;
  } sweep_t;

  typedef struct packed {
    logic                     wr;
    logic                     inc;
    logic                     clr;
    logic [IDX_W-1:0]         idx;
    logic [ID_WIDTH-1:0]      id;
    logic [PAYLOAD_WIDTH-1:0] pay;
  } act_t;

  typedef enum logic [1:0] {IDLE, SCAN, FIN} state_t;

  state_t                         state;
  logic [CNT_W-1:0]               count;
  logic [ID_WIDTH:0]              id_counter;
  logic [pptab_pkg::FUNC_W-1:0]   cmd_func;
  logic [ID_WIDTH-1:0]            cmd_id;
  logic [PAYLOAD_WIDTH-1:0]       cmd_pay;

  logic                           ovalid;
  logic [pptab_pkg::STATUS_W-1:0] ostatus;
  logic [ID_WIDTH-1:0]            oid;
  logic [PAYLOAD_WIDTH-1:0]       opay;
  logic [PRIORITY_WIDTH-1:0]      oprio;
  logic                           opresent;

  sweep_t chain [CAPACITY+1];
  sweep_t tail;
  act_t   act;
  logic   fire;

  logic [pptab_pkg::STATUS_W-1:0] res_status;
  logic [ID_WIDTH-1:0]            res_id;
  logic [PAYLOAD_WIDTH-1:0]       res_pay;
  logic [PRIORITY_WIDTH-1:0]      res_prio;
  logic                           res_present;

  assign chain[0] = '0;
  assign tail     = chain[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pptab_cell #(
      .INDEX(i), .IDX_W(IDX_W), .ID_WIDTH(ID_WIDTH),
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH), .PRIORITY_WIDTH(PRIORITY_WIDTH),
      .sweep_t(sweep_t), .act_t(act_t)
    ) u_cell (
      .clk(clk), .rst(rst), .cmd_id(cmd_id),
      .upstream(chain[i]), .downstream(chain[i+1]), .act(act)
    );
  end

  assign cmd.ready       = (state == IDLE);
  assign rsp.valid       = ovalid;
  assign rsp.status      = ostatus;
  assign rsp.result_id   = oid;
  assign rsp.payload_out = opay;
  assign rsp.priority_out = oprio;
  assign rsp.present     = opresent;

  assign fire = (state == FIN) && (!ovalid || rsp.ready);

  always_comb begin
    act         = '0;
    act.id      = id_counter[ID_WIDTH-1:0];
    act.pay     = cmd_pay;
    res_status  = pptab_pkg::ST_OK;
    res_id      = '0;
    res_pay     = '0;
    res_prio    = '0;
    res_present = 1'b0;
    unique case (cmd_func)
      pptab_pkg::FN_ADD: begin
        if (id_counter[ID_WIDTH]) begin
          res_status = pptab_pkg::ST_EXHAUSTED;
        end else if (!tail.free) begin
          res_status = pptab_pkg::ST_FULL;
        end else begin
          act.wr  = fire;
          act.idx = tail.free_idx;
          res_id  = id_counter[ID_WIDTH-1:0];
        end
      end
      pptab_pkg::FN_PROMOTE: begin
        if (!tail.hit) begin
          res_status = pptab_pkg::ST_UNKNOWN;
        end else begin
          res_id  = cmd_id;
          res_pay = tail.hit_pay;
          act.idx = tail.hit_idx;
          if (&tail.hit_prio) begin
            res_status = pptab_pkg::ST_SATURATED;
            res_prio   = tail.hit_prio;
          end else begin
            act.inc  = fire;
            res_prio = tail.hit_prio + 1'b1;
          end
        end
      end
      pptab_pkg::FN_PEEK, pptab_pkg::FN_POP: begin
        if (!tail.best) begin
          res_status = pptab_pkg::ST_EMPTY;
        end else begin
          res_id   = tail.best_id;
          res_pay  = tail.best_pay;
          res_prio = tail.best_prio;
          act.idx  = tail.best_idx;
          act.clr  = fire && (cmd_func == pptab_pkg::FN_POP);
        end
      end
      pptab_pkg::FN_LOOKUP: begin
        res_id = cmd_id;
        if (!tail.hit) begin
          res_status = pptab_pkg::ST_UNKNOWN;
        end else begin
          res_present = 1'b1;
          res_pay     = tail.hit_pay;
          res_prio    = tail.hit_prio;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      count      <= '0;
      id_counter <= '0;
      ovalid     <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.valid) begin
            state <= SCAN;
            count <= '0;
          end
        end
        SCAN: begin
          count <= count + 1'b1;
          if (count == CNT_W'(CAPACITY - 1)) begin
            state <= FIN;
          end
        end
        FIN: begin
          if (fire) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (fire) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
      if (act.wr) begin
        id_counter <= id_counter + 1'b1;
      end
    end
    if (state == IDLE && cmd.valid) begin
      cmd_func <= cmd.func;
      cmd_id   <= cmd.item_id;
      cmd_pay  <= cmd.payload_in;
    end
    if (fire) begin
      ostatus  <= res_status;
      oid      <= res_id;
      opay     <= res_pay;
      oprio    <= res_prio;
      opresent <= res_present;
    end
  end

  a_present_ok: assert property (@(posedge clk) disable iff (rst)
    ovalid && opresent |-> ostatus == pptab_pkg::ST_OK)
    else $error("present set with non-ok status");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    id_counter[ID_WIDTH] |-> id_counter[ID_WIDTH-1:0] == '0)
    else $error("id counter past its end");

  a_write_in_fin: assert property (@(posedge clk) disable iff (rst)
    (act.wr || act.clr || act.inc) |-> state == FIN && $past(state) != IDLE)
    else $error("slot update outside decision cycle");

  a_rsp_after_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(ovalid) |-> $past(state) == FIN)
    else $error("response without completed sweep");

endmodule

[test/tb_promotable_priority_table.sv]
// Self-checking testbench for the promotable priority table.
`timescale 1ns / 100ps

module tb_promotable_priority_table;

  localparam int CAP = pptab_pkg::CAPACITY;
  localparam int IDW = pptab_pkg::ID_WIDTH;
  localparam int PW  = pptab_pkg::PAYLOAD_WIDTH;
  localparam int PRW = pptab_pkg::PRIORITY_WIDTH;
  localparam int FW  = pptab_pkg::FUNC_W;
  localparam int STW = pptab_pkg::STATUS_W;
  localparam logic [PRW-1:0] PRIO_TOP = '1;

  // codes with no operation behind them
  localparam logic [FW-1:0] FN_SPARE_5 = 3'd5;
  localparam logic [FW-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FW-1:0] FN_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [STW-1:0] status;
    logic [IDW-1:0] rid;
    logic [PW-1:0]  pay;
    logic [PRW-1:0] prio;
    logic           present;
  } answer_t;

  typedef struct {
    logic [FW-1:0]  func;
    logic [IDW-1:0] id;
    logic [PW-1:0]  pay;
    bit             typed;
    answer_t        ans;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  int   errors = 0;

  pptab_in_if  cmd ();
  pptab_out_if rsp ();

  promotable_priority_table u_top (.clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp));

  always #4 clk = ~clk;

  // shadow copy of the table
  bit             tbl_valid [CAP];
  logic [IDW-1:0] tbl_id    [CAP];
  logic [PRW-1:0] tbl_prio  [CAP];
  logic [PW-1:0]  tbl_pay   [CAP];
  logic [IDW:0]   next_id;

  answer_t expected_answers[$];
  answer_t typed_answers[$];
  bit      typed_flags[$];

  function automatic int find_entry(logic [IDW-1:0] id);
    for (int i = 0; i < CAP; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_top();
    int b;
    b = -1;
    for (int i = 0; i < CAP; i++) begin
      if (!tbl_valid[i]) continue;
      if (b < 0 || tbl_prio[i] > tbl_prio[b] ||
          (tbl_prio[i] == tbl_prio[b] && tbl_id[i] > tbl_id[b])) b = i;
    end
    return b;
  endfunction

  function automatic int count_entries();
    int n;
    n = 0;
    for (int i = 0; i < CAP; i++) n += tbl_valid[i];
    return n;
  endfunction

  function automatic answer_t apply_command(logic [FW-1:0] f, logic [IDW-1:0] id,
                                            logic [PW-1:0] pay);
    answer_t a;
    int s;
    a = '0;
    case (f)
      pptab_pkg::FN_ADD: begin
        if (next_id[IDW]) begin
          a.status = pptab_pkg::ST_EXHAUSTED;
        end else begin
          s = -1;
          for (int i = 0; i < CAP; i++)
            if (!tbl_valid[i]) begin
              s = i;
              break;
            end
          if (s < 0) begin
            a.status = pptab_pkg::ST_FULL;
          end else begin
            tbl_valid[s] = 1;
            tbl_id[s] = next_id[IDW-1:0];
            tbl_prio[s] = '0;
            tbl_pay[s] = pay;
            a.rid = next_id[IDW-1:0];
            next_id++;
          end
        end
      end
      pptab_pkg::FN_PROMOTE: begin
        s = find_entry(id);
        if (s < 0) begin
          a.status = pptab_pkg::ST_UNKNOWN;
        end else begin
          a.rid = id;
          a.pay = tbl_pay[s];
          if (tbl_prio[s] == PRIO_TOP) a.status = pptab_pkg::ST_SATURATED;
          else tbl_prio[s]++;
          a.prio = tbl_prio[s];
        end
      end
      pptab_pkg::FN_PEEK, pptab_pkg::FN_POP: begin
        s = find_top();
        if (s < 0) begin
          a.status = pptab_pkg::ST_EMPTY;
        end else begin
          a.rid = tbl_id[s];
          a.pay = tbl_pay[s];
          a.prio = tbl_prio[s];
          if (f == pptab_pkg::FN_POP) tbl_valid[s] = 0;
        end
      end
      pptab_pkg::FN_LOOKUP: begin
        s = find_entry(id);
        a.rid = id;
        if (s < 0) begin
          a.status = pptab_pkg::ST_UNKNOWN;
        end else begin
          a.present = 1;
          a.pay = tbl_pay[s];
          a.prio = tbl_prio[s];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // sender
  int burst_left = 0;

  task automatic send_word(logic [FW-1:0] f, logic [IDW-1:0] id,
                           logic [PW-1:0] pay, bit typed, answer_t typed_ans);
    answer_t a;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        cmd.valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    a = apply_command(f, id, pay);
    expected_answers = {expected_answers, a};
    typed_answers = {typed_answers, typed_ans};
    typed_flags = {typed_flags, typed};
    cmd.valid <= 1;
    cmd.func <= f;
    cmd.item_id <= id;
    cmd.payload_in <= pay;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    // valid stays up here; the next call or drain decides what follows
    @(negedge clk);
  endtask

  task automatic drain();
    cmd.valid <= 0;
    @(negedge clk);
    while (expected_answers.size() != 0) @(negedge clk);
  endtask

  // receiver: fixed-length stall pattern with random drops in its second part
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 23;
    if (rst) rsp.ready <= 0;
    else if (stall_phase < 8) rsp.ready <= 1;
    else rsp.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic check_field(string name, logic [63:0] e, logic [63:0] g);
    if (e !== g) begin
      $error("%s mismatch: expected %0h, got %0h", name, e, g);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    answer_t e, t;
    bit tf;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_answers.size() == 0) begin
        $error("response word with nothing expected");
        errors++;
      end else begin
        e = expected_answers.pop_front();
        t = typed_answers.pop_front();
        tf = typed_flags.pop_front();
        if (tf && t !== e) begin
          $error("typed row disagrees with predictor: typed %h, predicted %h", t, e);
          errors++;
        end
        check_field("status", 64'(e.status), 64'(rsp.status));
        check_field("result_id", 64'(e.rid), 64'(rsp.result_id));
        check_field("payload_out", 64'(e.pay), 64'(rsp.payload_out));
        check_field("priority_out", 64'(e.prio), 64'(rsp.priority_out));
        check_field("present", 64'(e.present), 64'(rsp.present));
      end
    end
  end

  function automatic answer_t mk(int st, int rid, logic [PW-1:0] pay, int pr, int pres);
    answer_t a;
    a.status = STW'(st);
    a.rid = IDW'(rid);
    a.pay = pay;
    a.prio = PRW'(pr);
    a.present = 1'(pres);
    return a;
  endfunction

  function automatic logic [IDW-1:0] pick_id();
    int live[$];
    for (int i = 0; i < CAP; i++) if (tbl_valid[i]) live = {live, i};
    if (live.size() == 0 || $urandom_range(0, 9) == 0) return IDW'($urandom);
    return tbl_id[live[$urandom_range(0, live.size() - 1)]];
  endfunction

  stim_row_t rows[$];
  answer_t   nil;

  initial begin
    int f;
    nil = '0;
    cmd.valid = 0;
    cmd.func = pptab_pkg::FN_ADD;
    cmd.item_id = '0;
    cmd.payload_in = '0;
    next_id = '0;
    foreach (tbl_valid[i]) tbl_valid[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed rows: empty table, extremes, unknown id, unused codes
    rows = '{
      '{pptab_pkg::FN_PEEK, 16'h0, 32'h0, 1, mk(pptab_pkg::ST_EMPTY, 0, 0, 0, 0)},
      '{pptab_pkg::FN_POP, 16'h0, 32'h0, 1, mk(pptab_pkg::ST_EMPTY, 0, 0, 0, 0)},
      '{pptab_pkg::FN_LOOKUP, 16'hffff, 32'h0, 1,
        mk(pptab_pkg::ST_UNKNOWN, 16'hffff, 0, 0, 0)},
      '{pptab_pkg::FN_PROMOTE, 16'h0, 32'h0, 1, mk(pptab_pkg::ST_UNKNOWN, 0, 0, 0, 0)},
      '{FN_SPARE_5, 16'hffff, 32'hffffffff, 1, nil},
      '{FN_SPARE_6, 16'h0, 32'h0, 1, nil},
      '{FN_SPARE_7, 16'hffff, 32'hffffffff, 1, nil},
      '{pptab_pkg::FN_ADD, 16'hffff, 32'hffffffff, 1, mk(pptab_pkg::ST_OK, 0, 0, 0, 0)},
      '{pptab_pkg::FN_ADD, 16'h0, 32'h0, 1, mk(pptab_pkg::ST_OK, 1, 0, 0, 0)},
      '{pptab_pkg::FN_ADD, 16'h0, 32'h5a5a5a5a, 1, mk(pptab_pkg::ST_OK, 2, 0, 0, 0)},
      '{pptab_pkg::FN_LOOKUP, 16'h0, 32'h0, 1,
        mk(pptab_pkg::ST_OK, 0, 32'hffffffff, 0, 1)},
      '{pptab_pkg::FN_PEEK, 16'h0, 32'h0, 1,
        mk(pptab_pkg::ST_OK, 2, 32'h5a5a5a5a, 0, 0)},
      '{pptab_pkg::FN_PROMOTE, 16'h0, 32'h0, 1,
        mk(pptab_pkg::ST_OK, 0, 32'hffffffff, 1, 0)},
      '{pptab_pkg::FN_PEEK, 16'h0, 32'h0, 1,
        mk(pptab_pkg::ST_OK, 0, 32'hffffffff, 1, 0)},
      '{pptab_pkg::FN_POP, 16'h0, 32'h0, 1,
        mk(pptab_pkg::ST_OK, 0, 32'hffffffff, 1, 0)},
      '{pptab_pkg::FN_LOOKUP, 16'h0, 32'h0, 1, mk(pptab_pkg::ST_UNKNOWN, 0, 0, 0, 0)},
      '{pptab_pkg::FN_PROMOTE, 16'h1, 32'h0, 0, nil},
      '{pptab_pkg::FN_POP, 16'h0, 32'h0, 0, nil},
      '{pptab_pkg::FN_POP, 16'h0, 32'h0, 0, nil},
      '{pptab_pkg::FN_POP, 16'h0, 32'h0, 1, mk(pptab_pkg::ST_EMPTY, 0, 0, 0, 0)}
    };
    foreach (rows[i])
      send_word(rows[i].func, rows[i].id, rows[i].pay, rows[i].typed, rows[i].ans);

    // fill to capacity, then one add past full
    while (count_entries() < CAP)
      send_word(pptab_pkg::FN_ADD, IDW'($urandom), PW'($urandom), 0, nil);
    send_word(pptab_pkg::FN_ADD, '0, PW'($urandom), 1,
              mk(pptab_pkg::ST_FULL, 0, 0, 0, 0));
    drain();

    // random traffic, mostly mid-occupancy
    for (int n = 0; n < 320; n++) begin
      if (n == 160) drain();
      f = $urandom_range(0, 99);
      if (f < 30)
        send_word(pptab_pkg::FN_ADD, IDW'($urandom), PW'($urandom), 0, nil);
      else if (f < 55)
        send_word(pptab_pkg::FN_PROMOTE, pick_id(), PW'($urandom), 0, nil);
      else if (f < 67)
        send_word(pptab_pkg::FN_PEEK, IDW'($urandom), PW'($urandom), 0, nil);
      else if (f < 82)
        send_word(pptab_pkg::FN_POP, IDW'($urandom), PW'($urandom), 0, nil);
      else if (f < 97)
        send_word(pptab_pkg::FN_LOOKUP, pick_id(), PW'($urandom), 0, nil);
      else
        send_word(FW'($urandom_range(5, 7)), IDW'($urandom), PW'($urandom), 0, nil);
    end
    drain();
    repeat (3 * CAP) @(negedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // about 400 words plus stalls fit well inside this
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/pptab_pkg.sv
rtl/pptab_if.sv
rtl/pptab_cell.sv
rtl/promotable_priority_table.sv
test/tb_promotable_priority_table.sv
